FILE: hw/rtl/svm_pkg.sv
// svm_pkg: opcodes, fault codes, sequencer states and control bundles
// shared by the stack machine execute unit and its memory and divider.
// no dependencies
package svm_pkg;

  localparam logic [31:0] INC_PTR       = 32'd4;
  localparam logic [31:0] CODE_SEG_MASK = 32'hF000_0000;
  localparam logic [31:0] STACK_TOP_RST = 32'd4096;

  typedef enum logic [5:0] {
    OP_IMM  = 6'd0,  OP_IMX  = 6'd1,  OP_LOAD = 6'd2,  OP_SAVE = 6'd3,
    OP_PUSH = 6'd4,  OP_POP  = 6'd5,  OP_JMP  = 6'd6,  OP_JZ   = 6'd7,
    OP_JNZ  = 6'd8,  OP_CALL = 6'd9,  OP_ENT  = 6'd10, OP_ADJ  = 6'd11,
    OP_LEV  = 6'd12, OP_LEA  = 6'd13, OP_OR   = 6'd14, OP_XOR  = 6'd15,
    OP_AND  = 6'd16, OP_EQ   = 6'd17, OP_CASE = 6'd18, OP_NE   = 6'd19,
    OP_LT   = 6'd20, OP_LE   = 6'd21, OP_GT   = 6'd22, OP_GE   = 6'd23,
    OP_SHL  = 6'd24, OP_SHR  = 6'd25, OP_ADD  = 6'd26, OP_SUB  = 6'd27,
    OP_MUL  = 6'd28, OP_DIV  = 6'd29, OP_MOD  = 6'd30, OP_EXIT = 6'd31,
    OP_RESTART = 6'd32
  } op_t;

  typedef enum logic [2:0] {
    F_NONE = 3'd0, F_ADDR = 3'd1, F_CODE = 3'd2, F_DIVZ = 3'd3, F_UNK = 3'd4
  } fault_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RDA, ST_RDB, ST_LDB, ST_EXEC, ST_DIV, ST_WCHK
  } state_t;

  localparam logic [1:0] CFG_CODE_BASE = 2'd0;
  localparam logic [1:0] CFG_MEM_BASE  = 2'd1;
  localparam logic [1:0] CFG_STACK_TOP = 2'd2;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_byte;
  } mem_ctl_t;

  typedef struct packed {
    logic start;
    logic is_mod;
  } div_ctl_t;

endpackage

FILE: hw/rtl/svm_mem.sv
// svm_mem: byte-addressed data and stack memory as four byte banks,
// unaligned word access, cleared by a sweep after reset. uses svm_pkg.
module svm_mem
  import svm_pkg::*;
#(
  parameter int MEM_WORDS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mem_ctl_t                      ctl,
  input  logic [$clog2(MEM_WORDS)+1:0]  rd_off,
  input  logic [$clog2(MEM_WORDS)+1:0]  wr_off,
  input  logic [31:0]                   wr_data,
  output logic [31:0]                   rd_data,
  output logic                          busy
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam int OW = AW + 2;

  logic [AW-1:0] clr_row_r;
  logic          clr_busy_r;
  logic [1:0]    rot_r;
  logic [7:0]    q_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_row_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_row_r <= clr_row_r + AW'(1);
      if (clr_row_r == AW'(MEM_WORDS - 1)) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) rot_r <= rd_off[1:0];
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]    mem [MEM_WORDS];
    logic [1:0]    rlane, wlane;
    logic [OW-1:0] rsum, wsum;
    logic          wen;

    // each bank serves the lane whose byte falls into it
    assign rlane = 2'(b) - rd_off[1:0];
    assign wlane = 2'(b) - wr_off[1:0];
    assign rsum  = rd_off + OW'(rlane);
    assign wsum  = wr_off + OW'(wlane);
    assign wen   = ctl.wr_en && (!ctl.wr_byte || wlane == 2'd0);

    always_ff @(posedge clk) begin
      if (clr_busy_r) begin
        mem[clr_row_r] <= 8'd0;
      end else if (wen) begin
        mem[wsum[OW-1:2]] <= wr_data[8*wlane +: 8];
      end
      if (ctl.rd_en) q_r[b] <= mem[rsum[OW-1:2]];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rd_data[8*i +: 8] = q_r[2'(rot_r + 2'(i))];
    end
  end

  assign busy = clr_busy_r;

endmodule

FILE: hw/rtl/svm_div.sv
// svm_div: signed 32-bit divide and remainder, truncating, one quotient
// bit per cycle on magnitudes. uses svm_pkg.
module svm_div
  import svm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_ctl_t    ctl,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] result
);

  logic        busy_r, done_r, negq_r, negr_r, mod_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r, quo_r, den_r;
  logic [32:0] sh, diff;

  assign sh   = {rem_r, quo_r[31]};
  assign diff = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      // most negative value keeps its bit pattern, read as unsigned magnitude
      quo_r  <= dividend[31] ? 32'(-dividend) : dividend;
      den_r  <= divisor[31] ? 32'(-divisor) : divisor;
      rem_r  <= '0;
      cnt_r  <= '0;
      negq_r <= dividend[31] ^ divisor[31];
      negr_r <= dividend[31];
      mod_r  <= ctl.is_mod;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (!diff[32]) begin
        rem_r <= diff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= sh[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  assign done   = done_r;
  assign result = mod_r ? (negr_r ? 32'(-rem_r) : rem_r)
                        : (negq_r ? 32'(-quo_r) : quo_r);

endmodule

FILE: hw/rtl/stack_vm_instruction_execute.sv
// stack_vm_instruction_execute: executes one decoded instruction of an
// accumulator-plus-stack machine per item.
// uses svm_pkg, svm_mem and svm_div.
//
// input channel in_*: in_tuser carries the opcode, in_tdata the operand words.
// result channel out_*: new ax, next pc, sp, fault code and exit flag.
// configuration: cfg_we with cfg_addr 0 code base, 1 memory base, 2 stack top;
// takes effect when written, also for an item in flight; sp and pc reload only on reset or restart.
// an item runs through a sequencer around one byte-banked memory with a
// registered read: issue first read, issue second read, execute, write check
// and commit. LEV, which reads two stack words one after the other, adds a
// state that captures the second word; DIV and MOD wait in a divide state
// until the divider has run its 32 quotient steps. the next item is taken
// only when the sequencer is back in idle after commit.
// the result sits in an output register; the next item is accepted while it
// waits, but commit stalls until the register is free when the receiver
// holds out_tready low.
// after reset the memory is cleared row by row while in_tready stays low;
// configuration writes are taken throughout.
module stack_vm_instruction_execute
  import svm_pkg::*;
#(
  parameter int MEM_WORDS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [5:0]   in_tuser,   // operation
  input  logic [63:0]  in_tdata,   // operand, second_operand
  output logic         out_tvalid,
  input  logic         out_tready,
  // accumulator, next_pc, stack_pointer, fault, exited, zero pad
  output logic [103:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam int OW = AW + 2;
  localparam int MEM_BYTES = MEM_WORDS * 4;

  state_t state_r, state_nxt;

  logic [31:0] code_base_r, mem_base_r, stack_top_r;
  logic [31:0] ax_r, bp_r, sp_r, pc_r;
  logic        halt_r;

  logic [5:0]  op_r;
  logic [31:0] opd_r, opd2_r, d1_r, d2_r;
  logic        fa_r, fb_r;

  logic [31:0] pax_r, pbp_r, psp_r, ppc_r, wa_r, wv_r;
  logic        phalt_r, pex_r, wword_r, wany_r;
  fault_t      pfault_r;

  logic [31:0] pax_nxt, pbp_nxt, psp_nxt, ppc_nxt, wa_nxt, wv_nxt;
  logic        phalt_nxt, pex_nxt, wword_nxt, wany_nxt, go_div;
  fault_t      pfault_nxt;

  logic        out_valid_r;
  logic [99:0] out_data_r;

  mem_ctl_t    mem_ctl;
  div_ctl_t    div_ctl;
  logic        mem_busy, div_done, commit, in_accept;
  logic [31:0] rd_data, div_res;

  logic [31:0] a_addr, a_off, b_addr, b_off, w_off, npc, tgt;
  logic [2:0]  a_size;
  logic        a_win, b_win, w_win;
  fault_t      fin_fault;

  assign in_accept = in_tvalid && in_tready;

  // first read: load address, frame pointer for LEV, else top of stack
  always_comb begin
    case (op_r)
      OP_LOAD: a_addr = ax_r;
      OP_LEV:  a_addr = bp_r;
      default: a_addr = sp_r;
    endcase
  end
  assign a_size = (op_r == OP_LOAD && opd_r == 32'd1) ? 3'd1 : 3'd4;
  assign a_off  = a_addr - mem_base_r;
  assign a_win  = ({1'b0, a_off} + 33'(a_size)) <= 33'(MEM_BYTES);
  assign b_addr = bp_r + INC_PTR;
  assign b_off  = b_addr - mem_base_r;
  assign b_win  = ({1'b0, b_off} + 33'd4) <= 33'(MEM_BYTES);

  assign w_off  = wa_r - mem_base_r;
  assign w_win  = ({1'b0, w_off} + (wword_r ? 33'd4 : 33'd1)) <= 33'(MEM_BYTES);

  always_comb begin
    if (pfault_r != F_NONE) fin_fault = pfault_r;
    else if (wany_r && !w_win)
      fin_fault = ((wa_r & CODE_SEG_MASK) == (code_base_r & CODE_SEG_MASK))
                  ? F_CODE : F_ADDR;
    else fin_fault = F_NONE;
  end

  svm_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_off  (state_r == ST_RDB ? b_off[OW-1:0] : a_off[OW-1:0]),
    .wr_off  (w_off[OW-1:0]),
    .wr_data (wv_r),
    .rd_data (rd_data),
    .busy    (mem_busy)
  );

  svm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (d1_r),
    .divisor  (ax_r),
    .done     (div_done),
    .result   (div_res)
  );

  // execute: everything but the divide and the write window check
  assign npc = pc_r + INC_PTR;
  assign tgt = code_base_r + {opd_r[29:0], 2'b00};

  always_comb begin
    pax_nxt    = ax_r;
    pbp_nxt    = bp_r;
    psp_nxt    = sp_r;
    ppc_nxt    = npc;
    phalt_nxt  = halt_r;
    pex_nxt    = 1'b0;
    pfault_nxt = F_NONE;
    wa_nxt     = sp_r - INC_PTR;
    wv_nxt     = ax_r;
    wword_nxt  = 1'b1;
    wany_nxt   = 1'b0;
    go_div     = 1'b0;
    if (op_r == OP_RESTART) begin
      pax_nxt   = '0;
      pbp_nxt   = '0;
      psp_nxt   = stack_top_r;
      ppc_nxt   = code_base_r;
      phalt_nxt = 1'b0;
    end else if (halt_r) begin
      ppc_nxt = pc_r;
      pex_nxt = 1'b1;
    end else begin
      case (op_r)
        OP_IMM: begin
          pax_nxt = opd_r;
          ppc_nxt = npc + INC_PTR;
        end
        OP_IMX: begin
          pax_nxt = opd_r;
          ppc_nxt = npc + {opd2_r[0] & 1'b0, 31'd8};
        end
        OP_LOAD: begin
          pfault_nxt = fa_r ? F_ADDR : F_NONE;
          pax_nxt    = (opd_r == 32'd1) ? {24'd0, d1_r[7:0]} : d1_r;
          ppc_nxt    = npc + INC_PTR;
        end
        OP_SAVE: begin
          pfault_nxt = fa_r ? F_ADDR : F_NONE;
          psp_nxt    = sp_r + INC_PTR;
          wa_nxt     = d1_r;
          wword_nxt  = opd_r != 32'd1;
          wany_nxt   = 1'b1;
          ppc_nxt    = npc + INC_PTR;
        end
        OP_PUSH: begin
          psp_nxt  = sp_r - INC_PTR;
          wany_nxt = 1'b1;
        end
        OP_POP: begin
          pfault_nxt = fa_r ? F_ADDR : F_NONE;
          pax_nxt    = d1_r;
          psp_nxt    = sp_r + INC_PTR;
        end
        OP_JMP:  ppc_nxt = tgt;
        OP_JZ:   ppc_nxt = (ax_r != '0) ? npc + INC_PTR : tgt;
        OP_JNZ:  ppc_nxt = (ax_r != '0) ? tgt : npc + INC_PTR;
        OP_CALL: begin
          psp_nxt  = sp_r - INC_PTR;
          wv_nxt   = npc + INC_PTR;
          wany_nxt = 1'b1;
          ppc_nxt  = tgt;
        end
        OP_ENT: begin
          wv_nxt   = bp_r;
          wany_nxt = 1'b1;
          pbp_nxt  = sp_r - INC_PTR;
          psp_nxt  = sp_r - INC_PTR - opd_r;
          ppc_nxt  = npc + INC_PTR;
        end
        OP_ADJ: begin
          psp_nxt = sp_r + {opd_r[29:0], 2'b00};
          ppc_nxt = npc + INC_PTR;
        end
        OP_LEV: begin
          pfault_nxt = fa_r ? F_ADDR : (fb_r ? F_ADDR : F_NONE);
          psp_nxt    = bp_r + 32'd8;
          pbp_nxt    = d1_r;
          ppc_nxt    = d2_r;
        end
        OP_LEA: begin
          pax_nxt = bp_r + opd_r;
          ppc_nxt = npc + INC_PTR;
        end
        OP_CASE: begin
          pfault_nxt = fa_r ? F_ADDR : F_NONE;
          if (d1_r == ax_r) begin
            psp_nxt = sp_r + INC_PTR;
            pax_nxt = '0;
          end else begin
            pax_nxt = 32'd1;
          end
        end
        OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE,
        OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
          // left operand popped from the stack, right operand is ax
          pfault_nxt = fa_r ? F_ADDR : F_NONE;
          psp_nxt    = sp_r + INC_PTR;
          case (op_r)
            OP_OR:  pax_nxt = d1_r | ax_r;
            OP_XOR: pax_nxt = d1_r ^ ax_r;
            OP_AND: pax_nxt = d1_r & ax_r;
            OP_EQ:  pax_nxt = {31'd0, d1_r == ax_r};
            OP_NE:  pax_nxt = {31'd0, d1_r != ax_r};
            OP_LT:  pax_nxt = {31'd0, $signed(d1_r) <  $signed(ax_r)};
            OP_LE:  pax_nxt = {31'd0, $signed(d1_r) <= $signed(ax_r)};
            OP_GT:  pax_nxt = {31'd0, $signed(d1_r) >  $signed(ax_r)};
            OP_GE:  pax_nxt = {31'd0, $signed(d1_r) >= $signed(ax_r)};
            OP_SHL: pax_nxt = d1_r << ax_r[4:0];
            OP_SHR: pax_nxt = 32'($signed(d1_r) >>> ax_r[4:0]);
            OP_ADD: pax_nxt = d1_r + ax_r;
            OP_SUB: pax_nxt = d1_r - ax_r;
            OP_MUL: pax_nxt = 32'(d1_r * ax_r);
            default: begin
              if (!fa_r && ax_r == '0) pfault_nxt = F_DIVZ;
              go_div = !fa_r && ax_r != '0;
            end
          endcase
        end
        OP_EXIT: begin
          ppc_nxt   = npc;
          pex_nxt   = 1'b1;
          phalt_nxt = 1'b1;
        end
        default: pfault_nxt = F_UNK;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_accept) state_nxt = ST_RDA;
      ST_RDA:  state_nxt = ST_RDB;
      ST_RDB:  state_nxt = (op_r == OP_LEV) ? ST_LDB : ST_EXEC;
      ST_LDB:  state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = go_div ? ST_DIV : ST_WCHK;
      ST_DIV:  if (div_done) state_nxt = ST_WCHK;
      ST_WCHK: if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = (state_r == ST_IDLE) && !mem_busy;
    commit         = (state_r == ST_WCHK) && (!out_valid_r || out_tready);
    mem_ctl.rd_en  = (state_r == ST_RDA) || (state_r == ST_RDB);
    mem_ctl.wr_en  = commit && wany_r && (fin_fault == F_NONE);
    mem_ctl.wr_byte = !wword_r;
    div_ctl.start  = (state_r == ST_EXEC) && go_div;
    div_ctl.is_mod = (op_r == OP_MOD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      code_base_r <= '0;
      mem_base_r  <= '0;
      stack_top_r <= STACK_TOP_RST;
      ax_r        <= '0;
      bp_r        <= '0;
      sp_r        <= STACK_TOP_RST;
      pc_r        <= '0;
      halt_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_CODE_BASE: code_base_r <= cfg_wdata;
          CFG_MEM_BASE:  mem_base_r  <= cfg_wdata;
          CFG_STACK_TOP: stack_top_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (commit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (commit && fin_fault == F_NONE) begin
        ax_r   <= pax_r;
        bp_r   <= pbp_r;
        sp_r   <= psp_r;
        pc_r   <= ppc_r;
        halt_r <= phalt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_tuser;
      opd_r  <= in_tdata[31:0];
      opd2_r <= in_tdata[63:32];
    end
    if (state_r == ST_RDA) fa_r <= !a_win;
    if (state_r == ST_RDB) begin
      fb_r <= !b_win;
      d1_r <= rd_data;
    end
    if (state_r == ST_LDB) d2_r <= rd_data;
    if (state_r == ST_EXEC) begin
      pax_r    <= pax_nxt;
      pbp_r    <= pbp_nxt;
      psp_r    <= psp_nxt;
      ppc_r    <= ppc_nxt;
      phalt_r  <= phalt_nxt;
      pex_r    <= pex_nxt;
      pfault_r <= pfault_nxt;
      wa_r     <= wa_nxt;
      wv_r     <= wv_nxt;
      wword_r  <= wword_nxt;
      wany_r   <= wany_nxt;
    end
    if (state_r == ST_DIV && div_done) pax_r <= div_res;
    if (commit) begin
      // a faulting item reports the machine unchanged
      if (fin_fault != F_NONE)
        out_data_r <= {1'b0, fin_fault, sp_r, pc_r, ax_r};
      else
        out_data_r <= {pex_r, F_NONE, psp_r, ppc_r, pax_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_data_r};

`ifndef NO_ASSERTIONS
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> ax_r != '0)
    else $error("divider started with zero divisor");

  a_restart_sp: assert property (@(posedge clk) disable iff (!rst_n)
    commit && op_r == OP_RESTART |=> sp_r == $past(stack_top_r))
    else $error("restart did not reload sp");

  a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
    commit && halt_r && op_r != OP_RESTART |=> pc_r == $past(pc_r))
    else $error("halted machine moved pc");

  a_fault_hold: assert property (@(posedge clk) disable iff (!rst_n)
    commit && fin_fault != F_NONE |=> ax_r == $past(ax_r) && sp_r == $past(sp_r))
    else $error("faulting item changed state");
`endif

endmodule
